/* rtl/csrsd_pkg.sv */
// ----------------------------------------------------------------------------
// csrsd_pkg: shared types and constants for the CSR row sort and dedup block
// Item and result layouts, operation codes, default parameter values and the
// control word broadcast along the sort cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package csrsd_pkg;

	// default parameter values
	localparam int MAX_ROW_ENTRIES_DEF = 32;
	localparam int COLUMN_BITS_DEF     = 20;
	localparam int POSITION_BITS_DEF   = 24;

	// fixed field widths of the item and result
	localparam int OP_W       = 2;
	localparam int COLUMN_W   = 20;
	localparam int POSITION_W = 24;
	localparam int COUNT_W    = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_ENTRY = 2'd0;
	localparam logic [OP_W-1:0] OP_END   = 2'd1;
	localparam logic [OP_W-1:0] OP_START = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [COLUMN_W-1:0]   column;
		logic [POSITION_W-1:0] source_position;
	} item_t;

	typedef struct packed {
		logic [COLUMN_W-1:0]   sorted_column;
		logic [POSITION_W-1:0] origin_position;
		logic [POSITION_W-1:0] packed_position;
		logic                  starts_unique;
		logic [COUNT_W-1:0]    row_unique_count;
		logic                  row_empty;
		logic                  row_overflow;
		logic                  last;
	} result_t;

	// control broadcast to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/csrsd_cell.sv */
// ----------------------------------------------------------------------------
// csrsd_cell: one slot of the insertion sort chain
// Holds one buffered entry. On insert it keeps its entry, takes the new one or
// takes its left neighbour's entry; on drain it takes its right neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module csrsd_cell #(
	parameter int IDX           = 0,
	parameter int FILL_W        = 6,
	parameter int COLUMN_BITS   = csrsd_pkg::COLUMN_BITS_DEF,
	parameter int POSITION_BITS = csrsd_pkg::POSITION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire csrsd_pkg::cell_ctl_t     ctl,
	input  wire logic [FILL_W-1:0]        fill,
	input  wire logic [COLUMN_BITS-1:0]   new_col,
	input  wire logic [POSITION_BITS-1:0] new_src,
	input  wire logic                     left_beyond,
	input  wire logic [COLUMN_BITS-1:0]   left_col,
	input  wire logic [POSITION_BITS-1:0] left_src,
	input  wire logic [COLUMN_BITS-1:0]   right_col,
	input  wire logic [POSITION_BITS-1:0] right_src,
	output logic                          beyond,
	output logic [COLUMN_BITS-1:0]        col,
	output logic [POSITION_BITS-1:0]      src
);

	logic [COLUMN_BITS-1:0]   col_q;
	logic [POSITION_BITS-1:0] src_q;
	logic                     occupied;

	// slot lies past the insertion point: empty, or strictly greater (keeps ties stable)
	assign occupied = (fill > FILL_W'(IDX));
	assign beyond   = !occupied || (col_q > new_col);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= right_col;
			src_q <= right_src;
		end else if (ctl.insert && beyond) begin
			if (left_beyond) begin
				col_q <= left_col;
				src_q <= left_src;
			end else begin
				col_q <= new_col;
				src_q <= new_src;
			end
		end
	end

	assign col = col_q;
	assign src = src_q;

endmodule

`default_nettype wire

/* rtl/csr_row_sort_dedup.sv */
// ----------------------------------------------------------------------------
// csr_row_sort_dedup: stable sort and deduplication of one sparse row at a time
// Row entries enter an insertion sort chain of cells one per cycle; end of row
// drains the chain in order, marking new unique columns and packed positions.
// ----------------------------------------------------------------------------
// Row entries and start items: one per cycle while not busy, no result;
// busy stays low. End of row with n entries: busy rises while the chain
// drains through cell 0, and n results follow one per cycle, each registered
// from cell 0 after busy is set. An empty row gives its single result in the
// cycle after the end item is taken, with busy left low.
// Reset clears fill count, overflow flag, packed count and drain control;
// the cell contents are left as they are.
`default_nettype none

module csr_row_sort_dedup #(
	parameter int MAX_ROW_ENTRIES = csrsd_pkg::MAX_ROW_ENTRIES_DEF,
	parameter int COLUMN_BITS     = csrsd_pkg::COLUMN_BITS_DEF,
	parameter int POSITION_BITS   = csrsd_pkg::POSITION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire csrsd_pkg::item_t   item,
	output logic                    strobe,
	output csrsd_pkg::result_t      result
);

	localparam int FILL_W = $clog2(MAX_ROW_ENTRIES + 1);
	localparam int CMIN   = (COLUMN_BITS < csrsd_pkg::COLUMN_W) ?
	                        COLUMN_BITS : csrsd_pkg::COLUMN_W;
	localparam int PMIN   = (POSITION_BITS < csrsd_pkg::POSITION_W) ?
	                        POSITION_BITS : csrsd_pkg::POSITION_W;
	localparam int CW     = csrsd_pkg::COUNT_W;

	logic                     busy_q;
	logic                     strobe_q;
	logic                     ovf_q;
	logic [FILL_W-1:0]        fill_q;
	logic [FILL_W-1:0]        rem_q;
	logic [CW-1:0]            uniq_q;
	logic [COLUMN_BITS-1:0]   prev_col_q;
	logic [POSITION_BITS-1:0] packed_q;
	csrsd_pkg::result_t       result_q;

	logic                     accept;
	logic                     room;
	logic [COLUMN_BITS-1:0]   new_col;
	logic [POSITION_BITS-1:0] new_src;
	csrsd_pkg::cell_ctl_t     ctl;

	logic [COLUMN_BITS-1:0]   chain_col    [MAX_ROW_ENTRIES];
	logic [POSITION_BITS-1:0] chain_src    [MAX_ROW_ENTRIES];
	logic                     chain_beyond [MAX_ROW_ENTRIES];

	logic                     head_starts;
	logic [CW-1:0]            uniq_next;
	logic [POSITION_BITS-1:0] head_packed;
	logic                     head_last;
	csrsd_pkg::result_t       head_result;
	csrsd_pkg::result_t       empty_result;

	assign accept = start && !busy_q;
	assign room   = (fill_q < FILL_W'(MAX_ROW_ENTRIES));

	// mask incoming fields to the configured widths
	always_comb begin
		new_col = '0;
		new_src = '0;
		new_col[CMIN-1:0] = item.column[CMIN-1:0];
		new_src[PMIN-1:0] = item.source_position[PMIN-1:0];
	end

	assign ctl.insert = accept && (item.op == csrsd_pkg::OP_ENTRY) && room;
	assign ctl.shift  = busy_q;

	// sort chain
	for (genvar i = 0; i < MAX_ROW_ENTRIES; i++) begin : g_cell
		logic                     l_beyond;
		logic [COLUMN_BITS-1:0]   l_col;
		logic [POSITION_BITS-1:0] l_src;
		logic [COLUMN_BITS-1:0]   r_col;
		logic [POSITION_BITS-1:0] r_src;

		if (i == 0) begin : g_head
			assign l_beyond = 1'b0;
			assign l_col    = '0;
			assign l_src    = '0;
		end else begin : g_body
			assign l_beyond = chain_beyond[i-1];
			assign l_col    = chain_col[i-1];
			assign l_src    = chain_src[i-1];
		end

		if (i == MAX_ROW_ENTRIES - 1) begin : g_tail
			assign r_col = '0;
			assign r_src = '0;
		end else begin : g_inner
			assign r_col = chain_col[i+1];
			assign r_src = chain_src[i+1];
		end

		csrsd_cell #(
			.IDX          (i),
			.FILL_W       (FILL_W),
			.COLUMN_BITS  (COLUMN_BITS),
			.POSITION_BITS(POSITION_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.fill       (fill_q),
			.new_col    (new_col),
			.new_src    (new_src),
			.left_beyond(l_beyond),
			.left_col   (l_col),
			.left_src   (l_src),
			.right_col  (r_col),
			.right_src  (r_src),
			.beyond     (chain_beyond[i]),
			.col        (chain_col[i]),
			.src        (chain_src[i])
		);
	end

	// result for the entry leaving cell 0
	assign head_starts = (uniq_q == '0) || (chain_col[0] != prev_col_q);
	assign uniq_next   = uniq_q + CW'(head_starts);
	assign head_packed = packed_q + POSITION_BITS'(uniq_next) - POSITION_BITS'(1);
	assign head_last   = (rem_q == FILL_W'(1));

	always_comb begin
		head_result = '0;
		head_result.sorted_column[CMIN-1:0]   = chain_col[0][CMIN-1:0];
		head_result.origin_position[PMIN-1:0] = chain_src[0][PMIN-1:0];
		head_result.packed_position[PMIN-1:0] = head_packed[PMIN-1:0];
		head_result.starts_unique             = head_starts;
		head_result.row_unique_count          = head_last ? uniq_next : '0;
		head_result.row_overflow              = ovf_q;
		head_result.last                      = head_last;

		empty_result = '0;
		empty_result.row_empty    = 1'b1;
		empty_result.row_overflow = ovf_q;
		empty_result.last         = 1'b1;
	end

	// control: fill, drain and running packed count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			strobe_q   <= 1'b0;
			ovf_q      <= 1'b0;
			fill_q     <= '0;
			rem_q      <= '0;
			uniq_q     <= '0;
			prev_col_q <= '0;
			packed_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (busy_q) begin
				strobe_q   <= 1'b1;
				uniq_q     <= uniq_next;
				prev_col_q <= chain_col[0];
				rem_q      <= rem_q - FILL_W'(1);
				if (head_last) begin
					busy_q   <= 1'b0;
					fill_q   <= '0;
					ovf_q    <= 1'b0;
					packed_q <= packed_q + POSITION_BITS'(uniq_next);
				end
			end else if (accept) begin
				unique case (item.op)
					csrsd_pkg::OP_ENTRY: begin
						if (room) begin
							fill_q <= fill_q + FILL_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					csrsd_pkg::OP_END: begin
						if (fill_q == '0) begin
							strobe_q <= 1'b1;
							ovf_q    <= 1'b0;
						end else begin
							busy_q <= 1'b1;
							rem_q  <= fill_q;
							uniq_q <= '0;
						end
					end
					csrsd_pkg::OP_START: begin
						packed_q <= '0;
						fill_q   <= '0;
						ovf_q    <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (busy_q) begin
			result_q <= head_result;
		end else if (accept && (item.op == csrsd_pkg::OP_END) && (fill_q == '0)) begin
			result_q <= empty_result;
		end
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = result_q;

	// checks
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> !busy_q)
		else $error("last result while still draining");

	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> strobe_q)
		else $error("drain cycle without result");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0) && (rem_q <= fill_q))
		else $error("drain count out of range");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_ROW_ENTRIES))
		else $error("fill beyond capacity");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.row_empty |-> result_q.last && !busy_q)
		else $error("empty row result malformed");

endmodule

`default_nettype wire

/* tb/csr_row_sort_dedup_tb.sv */
// ----------------------------------------------------------------------------
// csr_row_sort_dedup_tb: self-checking bench for the CSR row sort and dedup
// A short table of directed items, then random matrix rows of mixed length
// (empty, short, full and over capacity) with restarts and unused op codes.
// Every result is checked field by field, against the predictor or a canned result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module csr_row_sort_dedup_tb;

	localparam int ROW_CAP = csrsd_pkg::MAX_ROW_ENTRIES_DEF;
	localparam logic [csrsd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 440;

	// canned results for the rows that can be read off directly
	localparam csrsd_pkg::result_t NO_RESULT = '0;
	localparam csrsd_pkg::result_t EMPTY_ROW = {20'h00000, 24'h000000, 24'h000000,
		1'b0, 7'd0, 1'b1, 1'b0, 1'b1};
	localparam csrsd_pkg::result_t TOP_ENTRY = {20'hFFFFF, 24'hFFFFFF, 24'h000000,
		1'b1, 7'd1, 1'b0, 1'b0, 1'b1};

	typedef struct packed {
		csrsd_pkg::item_t   stim;
		logic               typed;
		csrsd_pkg::result_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 22;

	// directed items; typed rows carry their own expected result
	dir_row_t directed_table [DIR_ROWS] = '{
		{csrsd_pkg::OP_END,   20'h00000, 24'h000000, 1'b1, EMPTY_ROW},	// empty row after reset
		{csrsd_pkg::OP_ENTRY, 20'hFFFFF, 24'hFFFFFF, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_END,   20'h00000, 24'h000000, 1'b1, TOP_ENTRY},	// single entry, all ones
		{csrsd_pkg::OP_ENTRY, 20'h00000, 24'h000000, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_ENTRY, 20'h00005, 24'h000001, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_ENTRY, 20'h00000, 24'h000002, 1'b0, NO_RESULT},	// duplicate, keeps order
		{csrsd_pkg::OP_ENTRY, 20'h00005, 24'h000003, 1'b0, NO_RESULT},
		{OP_UNUSED,           20'hAAAAA, 24'h555555, 1'b0, NO_RESULT},	// ignored code
		{csrsd_pkg::OP_END,   20'h00000, 24'h000000, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_ENTRY, 20'h00003, 24'h00000A, 1'b0, NO_RESULT},	// one column only
		{csrsd_pkg::OP_ENTRY, 20'h00003, 24'h00000B, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_ENTRY, 20'h00003, 24'h00000C, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_END,   20'h00000, 24'h000000, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_ENTRY, 20'h00007, 24'h000009, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_START, 20'hFFFFF, 24'hFFFFFF, 1'b0, NO_RESULT},	// drops the partial row
		{csrsd_pkg::OP_END,   20'h00000, 24'h000000, 1'b1, EMPTY_ROW},
		{csrsd_pkg::OP_ENTRY, 20'h55555, 24'hAAAAAA, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_ENTRY, 20'hAAAAA, 24'h555555, 1'b0, NO_RESULT},
		{OP_UNUSED,           20'hFFFFF, 24'hFFFFFF, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_END,   20'hFFFFF, 24'hFFFFFF, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_START, 20'h00000, 24'h000000, 1'b0, NO_RESULT},
		{csrsd_pkg::OP_END,   20'h00000, 24'h000000, 1'b1, EMPTY_ROW}
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	csrsd_pkg::item_t   item;
	logic               strobe;
	csrsd_pkg::result_t result;

	// predictor state
	logic [csrsd_pkg::COLUMN_W-1:0]   row_col_buf [ROW_CAP];
	logic [csrsd_pkg::POSITION_W-1:0] row_src_buf [ROW_CAP];
	int unsigned                      row_fill;
	logic                             row_dropped;
	logic [csrsd_pkg::POSITION_W-1:0] packed_base;
	csrsd_pkg::result_t               row_results [$];
	csrsd_pkg::result_t               expected_results [$];
	csrsd_pkg::result_t               oldest_result;

	int unsigned failures;
	int unsigned items_accepted;
	int unsigned random_items;
	int unsigned rows_closed;
	int unsigned empty_rows;
	int unsigned overflow_rows;
	int unsigned matrix_starts;
	int unsigned ignored_items;
	int unsigned results_checked;
	bit          idle_allowed;

	csr_row_sort_dedup DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop should the block hang
	initial begin
		#200000;
		$display("Test completed with failures");
		$finish;
	end

	// sorts and numbers one row on end of row; fills row_results
	function automatic void predict_item(csrsd_pkg::item_t it);
		logic [csrsd_pkg::COLUMN_W-1:0]   c;
		logic [csrsd_pkg::POSITION_W-1:0] s;
		logic [csrsd_pkg::COLUMN_W-1:0]   prev;
		int unsigned                      j;
		int unsigned                      uniq;
		csrsd_pkg::result_t               r;
		row_results.delete();
		case (it.op)
			csrsd_pkg::OP_ENTRY: begin
				if (row_fill < ROW_CAP) begin
					row_col_buf[row_fill] = it.column;
					row_src_buf[row_fill] = it.source_position;
					row_fill++;
				end else begin
					row_dropped = 1'b1;
				end
			end
			csrsd_pkg::OP_START: begin
				packed_base = '0;
				row_fill = 0;
				row_dropped = 1'b0;
			end
			csrsd_pkg::OP_END: begin
				if (row_fill == 0) begin
					r = '0;
					r.row_empty = 1'b1;
					r.row_overflow = row_dropped;
					r.last = 1'b1;
					row_results.push_back(r);
				end else begin
					// stable insertion sort by column
					for (int i = 1; i < row_fill; i++) begin
						c = row_col_buf[i];
						s = row_src_buf[i];
						j = i;
						while (j > 0 && row_col_buf[j-1] > c) begin
							row_col_buf[j] = row_col_buf[j-1];
							row_src_buf[j] = row_src_buf[j-1];
							j--;
						end
						row_col_buf[j] = c;
						row_src_buf[j] = s;
					end
					uniq = 0;
					prev = '0;
					for (int k = 0; k < row_fill; k++) begin
						r = '0;
						r.sorted_column = row_col_buf[k];
						r.origin_position = row_src_buf[k];
						r.starts_unique = (k == 0) || (row_col_buf[k] != prev);
						if (r.starts_unique)
							uniq++;
						prev = row_col_buf[k];
						r.packed_position = packed_base
							+ csrsd_pkg::POSITION_W'(uniq) - 1'b1;
						r.row_overflow = row_dropped;
						if (k == row_fill - 1) begin
							r.last = 1'b1;
							r.row_unique_count = csrsd_pkg::COUNT_W'(uniq);
						end
						row_results.push_back(r);
					end
					packed_base = packed_base + csrsd_pkg::POSITION_W'(uniq);
				end
				row_fill = 0;
				row_dropped = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// presents one item from a falling edge, returns at the falling edge after it is taken
	task automatic send_item(csrsd_pkg::item_t it, logic typed, csrsd_pkg::result_t want);
		if (idle_allowed && $urandom_range(99) < 7) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_item(it);
		items_accepted++;
		case (it.op)
			csrsd_pkg::OP_END: begin
				rows_closed++;
				if (row_results[0].row_empty)
					empty_rows++;
				if (row_results[0].row_overflow)
					overflow_rows++;
			end
			csrsd_pkg::OP_START: matrix_starts++;
			OP_UNUSED: ignored_items++;
			default: ;
		endcase
		if (typed)
			expected_results.push_back(want);
		else
			foreach (row_results[k])
				expected_results.push_back(row_results[k]);
		@(negedge clk);
	endtask

	// holds the sender off until every outstanding result has come back
	task automatic wait_drained();
		int unsigned guard;
		guard = 0;
		start <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	// one matrix row with random content, plus the odd stray item
	task automatic send_matrix_row(int unsigned n_entries);
		csrsd_pkg::item_t               it;
		logic [csrsd_pkg::COLUMN_W-1:0] window;
		bit                             clustered;
		clustered = ($urandom_range(1) == 0);
		window = csrsd_pkg::COLUMN_W'($urandom);
		for (int k = 0; k < n_entries; k++) begin
			if ($urandom_range(99) < 3) begin
				it.op = OP_UNUSED;
				it.column = csrsd_pkg::COLUMN_W'($urandom);
				it.source_position = csrsd_pkg::POSITION_W'($urandom);
				send_item(it, 1'b0, NO_RESULT);
			end
			// broken row: a restart in the middle
			if ($urandom_range(199) == 0) begin
				it.op = csrsd_pkg::OP_START;
				it.column = csrsd_pkg::COLUMN_W'($urandom);
				it.source_position = csrsd_pkg::POSITION_W'($urandom);
				send_item(it, 1'b0, NO_RESULT);
				random_items++;
			end
			it.op = csrsd_pkg::OP_ENTRY;
			it.column = clustered ? window + csrsd_pkg::COLUMN_W'($urandom_range(7))
				: csrsd_pkg::COLUMN_W'($urandom);
			it.source_position = csrsd_pkg::POSITION_W'($urandom);
			send_item(it, 1'b0, NO_RESULT);
			random_items++;
			idle_allowed = (random_items < 150) || (random_items >= 300);
		end
		it.op = csrsd_pkg::OP_END;
		it.column = csrsd_pkg::COLUMN_W'($urandom);
		it.source_position = csrsd_pkg::POSITION_W'($urandom);
		send_item(it, 1'b0, NO_RESULT);
		random_items++;
	endtask

	// result checker
	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: column %0h, origin %0h",
					result.sorted_column, result.origin_position);
				failures++;
			end else begin
				oldest_result = expected_results.pop_front();
				results_checked++;
				check_field("sorted_column", oldest_result.sorted_column,
					result.sorted_column);
				check_field("origin_position", oldest_result.origin_position,
					result.origin_position);
				check_field("packed_position", oldest_result.packed_position,
					result.packed_position);
				check_field("starts_unique", oldest_result.starts_unique,
					result.starts_unique);
				check_field("row_unique_count", oldest_result.row_unique_count,
					result.row_unique_count);
				check_field("row_empty", oldest_result.row_empty, result.row_empty);
				check_field("row_overflow", oldest_result.row_overflow,
					result.row_overflow);
				check_field("last", oldest_result.last, result.last);
			end
		end
	end

	// stimulus
	initial begin
		csrsd_pkg::item_t it;
		int unsigned      pick;
		int unsigned      row_len;
		bit               paused;
		failures = 0;
		items_accepted = 0;
		random_items = 0;
		rows_closed = 0;
		empty_rows = 0;
		overflow_rows = 0;
		matrix_starts = 0;
		ignored_items = 0;
		results_checked = 0;
		idle_allowed = 1'b1;
		paused = 1'b0;
		row_fill = 0;
		row_dropped = 1'b0;
		packed_base = '0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_table[k])
			send_item(directed_table[k].stim, directed_table[k].typed,
				directed_table[k].want);

		// first random row is sent with more entries than the row capacity
		send_matrix_row(ROW_CAP + 3);
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 8) begin
				it.op = csrsd_pkg::OP_START;
				it.column = csrsd_pkg::COLUMN_W'($urandom);
				it.source_position = csrsd_pkg::POSITION_W'($urandom);
				send_item(it, 1'b0, NO_RESULT);
				random_items++;
			end
			if (!paused && random_items >= 240) begin
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 5)
				row_len = 0;
			else if (pick < 72)
				row_len = $urandom_range(8, 1);
			else if (pick < 90)
				row_len = $urandom_range(ROW_CAP - 1, 9);
			else if (pick < 96)
				row_len = ROW_CAP;
			else
				row_len = $urandom_range(ROW_CAP + 6, ROW_CAP + 1);
			send_matrix_row(row_len);
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			failures += expected_results.size();
		end

		$display("Covered %0d items: %0d rows (%0d empty, %0d over capacity), %0d restarts,",
			items_accepted, rows_closed, empty_rows, overflow_rows, matrix_starts);
		$display("%0d unused op codes; %0d results compared field by field.",
			ignored_items, results_checked);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
rtl/csrsd_pkg.sv
rtl/csrsd_cell.sv
rtl/csr_row_sort_dedup.sv
tb/csr_row_sort_dedup_tb.sv
